/* src/nvbs_pkg.sv */
package nvbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int IDX_OUT_W   = 10;
  localparam int ACT_W       = 2;
  localparam int ST_W        = 2;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [DATA_W-1:0]    value;
    logic [ST_W-1:0]      status;
  } result_t;

endpackage

/* src/nvbs_ram.sv */
module nvbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* src/nvbs_ctrl.sv */
module nvbs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nvbs_pkg::ACT_W-1:0]    in_action,
  input  logic [nvbs_pkg::DATA_W-1:0]   in_value,
  output nvbs_pkg::mem_req_t            ram_req,
  input  logic [nvbs_pkg::DATA_W-1:0]   ram_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output nvbs_pkg::result_t             res
);

  localparam int ADDR_W = nvbs_pkg::ADDR_W;
  localparam int CNT_W  = nvbs_pkg::CNT_W;
  localparam int DATA_W = nvbs_pkg::DATA_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_UP    = 3'd4;
  localparam logic [2:0] S_DOWN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] v_r, v_nxt;
  // lo and hi+1 of the search window; hi+1 stays unsigned since hi may reach -1.
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hp_r, hp_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [ADDR_W-1:0] li_r, li_nxt;
  logic [ADDR_W-1:0] hj_r, hj_nxt;
  logic [DATA_W-1:0] upv_r, upv_nxt;
  logic [DATA_W:0]   gap_r, gap_nxt;
  nvbs_pkg::result_t res_r, res_nxt;

  logic [CNT_W-1:0]  last_cnt;
  logic [ADDR_W-1:0] last_a;
  logic [CNT_W-1:0]  plo, php;
  logic [CNT_W:0]    psum;
  logic [DATA_W:0]   down_gap;
  logic              accept;

  assign last_cnt = cnt_r - CNT_W'(1);
  assign last_a   = last_cnt[ADDR_W-1:0];
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res = res_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    lo_nxt    = lo_r;
    hp_nxt    = hp_r;
    mid_nxt   = mid_r;
    li_nxt    = li_r;
    hj_nxt    = hj_r;
    upv_nxt   = upv_r;
    gap_nxt   = gap_r;
    res_nxt   = res_r;
    ram_req   = '0;
    plo       = lo_r;
    php       = hp_r;
    psum      = '0;
    down_gap  = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          v_nxt     = in_value;
          state_nxt = S_DONE;
          case (in_action)
            nvbs_pkg::ACT_LOAD: begin
              if (cnt_r < CNT_W'(nvbs_pkg::TABLE_DEPTH)) begin
                ram_req.we    = 1'b1;
                ram_req.addr  = cnt_r[ADDR_W-1:0];
                ram_req.wdata = in_value;
                cnt_nxt       = cnt_r + CNT_W'(1);
              end else begin
                res_nxt.status = nvbs_pkg::ST_FULL;
              end
            end
            nvbs_pkg::ACT_QUERY: begin
              if (cnt_r == '0) begin
                res_nxt.status = nvbs_pkg::ST_EMPTY;
              end else begin
                ram_req.addr = '0;
                state_nxt    = S_FIRST;
              end
            end
            nvbs_pkg::ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_FIRST: begin
        if (v_r < ram_rdata) begin
          res_nxt.index = '0;
          res_nxt.value = ram_rdata;
          state_nxt     = S_DONE;
        end else begin
          ram_req.addr = last_a;
          state_nxt    = S_LAST;
        end
      end

      S_LAST: begin
        if (v_r > ram_rdata) begin
          res_nxt.index = nvbs_pkg::IDX_OUT_W'(last_a);
          res_nxt.value = ram_rdata;
          state_nxt     = S_DONE;
        end else begin
          lo_nxt       = '0;
          hp_nxt       = cnt_r;
          psum         = (CNT_W+1)'(last_cnt);
          mid_nxt      = psum[ADDR_W:1];
          ram_req.addr = psum[ADDR_W:1];
          state_nxt    = S_PROBE;
        end
      end

      S_PROBE: begin
        if (v_r == ram_rdata) begin
          res_nxt.index = nvbs_pkg::IDX_OUT_W'(mid_r);
          res_nxt.value = ram_rdata;
          state_nxt     = S_DONE;
        end else begin
          if (v_r < ram_rdata) begin
            plo = lo_r;
            php = CNT_W'(mid_r);
          end else begin
            plo = CNT_W'(mid_r) + CNT_W'(1);
            php = hp_r;
          end
          lo_nxt = plo;
          hp_nxt = php;
          if (plo < php) begin
            psum         = (CNT_W+1)'(plo) + (CNT_W+1)'(php) - (CNT_W+1)'(1);
            mid_nxt      = psum[ADDR_W:1];
            ram_req.addr = psum[ADDR_W:1];
          end else begin
            // Window closed: fetch both neighbors, clamped to the filled range.
            li_nxt       = (plo >= cnt_r) ? last_a : plo[ADDR_W-1:0];
            hj_nxt       = (php == '0) ? '0 : ADDR_W'(php - CNT_W'(1));
            ram_req.addr = (plo >= cnt_r) ? last_a : plo[ADDR_W-1:0];
            state_nxt    = S_UP;
          end
        end
      end

      S_UP: begin
        upv_nxt      = ram_rdata;
        gap_nxt      = {1'b0, ram_rdata} - {1'b0, v_r};
        ram_req.addr = hj_r;
        state_nxt    = S_DOWN;
      end

      S_DOWN: begin
        down_gap = {1'b0, v_r} - {1'b0, ram_rdata};
        if ($signed(gap_r) < $signed(down_gap)) begin
          res_nxt.index = nvbs_pkg::IDX_OUT_W'(li_r);
          res_nxt.value = upv_r;
        end else begin
          res_nxt.index = nvbs_pkg::IDX_OUT_W'(hj_r);
          res_nxt.value = ram_rdata;
        end
        res_nxt.status = nvbs_pkg::ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    v_r   <= v_nxt;
    lo_r  <= lo_nxt;
    hp_r  <= hp_nxt;
    mid_r <= mid_nxt;
    li_r  <= li_nxt;
    hj_r  <= hj_nxt;
    upv_r <= upv_nxt;
    gap_r <= gap_nxt;
    res_r <= res_nxt;
  end

endmodule

/* src/nearest_value_binary_search.sv */
// Nearest-value lookup over an ascending table of boundary positions.
// Input channel (in_*): in_tuser carries the action (load at end, query,
// clear) and in_tdata the 32-bit value to load or to search for.
// Result channel (out_*): exactly one transaction per input transaction,
// in order, carrying the nearest entry index and value in out_tdata and
// the status (ok, query on empty table, load dropped on full table) in
// out_tuser.
// A load, a clear or an unused action code goes from input acceptance
// straight to the result state and then into the output register. A query
// reads the single-port table once per cycle: the first entry, the last
// entry, one probe per binary-search step (up to log2(entries)+1), and the
// two neighbors of the closed window. That single memory port sets the
// rate; one item is worked on at a time.
// The input side accepts a new transaction while a finished result still
// waits in the output register, so a stalled receiver holds back at most
// one further item before in_tready drops.
// Reset empties the table (entry count to zero) and drops any pending
// result; table contents are not cleared and are only read below the count.
module nearest_value_binary_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [9:0] nearest_index, [41:10] nearest_value, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  nvbs_pkg::mem_req_t                ram_req;
  logic [nvbs_pkg::DATA_W-1:0]       ram_rdata;
  logic                              res_valid;
  logic                              res_ready;
  nvbs_pkg::result_t                 res;
  nvbs_pkg::result_t                 out_r;
  logic                              out_vld_r;

  nvbs_ram #(
    .WIDTH (nvbs_pkg::DATA_W),
    .DEPTH (nvbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  nvbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_value  (in_tdata),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register takes a new result when empty or when its current
  // result leaves in the same cycle.
  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_r.value, out_r.index};
  assign out_tuser  = out_r.status;

endmodule

/* tb/sv/nearest_value_binary_search_tb.sv */
module nearest_value_binary_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code 3 has no meaning in the block; it must be ignored.
  localparam logic [nvbs_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 60;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [nvbs_pkg::ACT_W-1:0]  act;
    logic [nvbs_pkg::DATA_W-1:0] data;
    bit                          typed;
    nvbs_pkg::result_t           res;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;   // [31:0] data_value
  logic [1:0]        in_tuser = '0;   // [1:0] action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;       // [9:0] nearest_index, [41:10] nearest_value
  logic [1:0]        out_tuser;       // [1:0] status

  // Shadow copy of the boundary table and its fill level.
  logic [nvbs_pkg::DATA_W-1:0] boundary_copy [nvbs_pkg::TABLE_DEPTH];
  int                          entry_total = 0;

  // Results owed by the block, oldest first.
  nvbs_pkg::result_t pending_results [$];
  nvbs_pkg::result_t oldest_result;

  int                mismatch_count = 0;
  int                items_sent = 0;
  int                cycle_count = 0;
  int                stall_left = 0;
  bit                quiet = 1'b0;
  bit                sender_gaps = 1'b1;
  bit                receiver_gaps = 1'b1;

  nearest_value_binary_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bounds a probe position to the filled part of the table, as the search does.
  function automatic int clamp_probe(input longint pos);
    if (pos < 0) return 0;
    if (pos >= entry_total) return entry_total - 1;
    return int'(pos);
  endfunction

  // Binary search for the entry nearest to the key. The edges of the table
  // are checked first; when the window closes without an exact hit, the lower
  // neighbor wins unless the upper one is strictly closer.
  function automatic int nearest_entry(input logic [nvbs_pkg::DATA_W-1:0] key);
    int     last;
    longint lo;
    longint hi;
    longint mid;
    int     probe;
    int     up_idx;
    int     down_idx;
    longint up_gap;
    longint down_gap;
    last = entry_total - 1;
    lo = 0;
    hi = last;
    if (key < boundary_copy[0]) return 0;
    if (key > boundary_copy[last]) return last;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      probe = clamp_probe(mid);
      if (key < boundary_copy[probe]) hi = mid - 1;
      else if (key > boundary_copy[probe]) lo = mid + 1;
      else return probe;
    end
    up_idx = clamp_probe(lo);
    down_idx = clamp_probe(hi);
    up_gap = longint'({32'd0, boundary_copy[up_idx]}) - longint'({32'd0, key});
    down_gap = longint'({32'd0, key}) - longint'({32'd0, boundary_copy[down_idx]});
    return (up_gap < down_gap) ? up_idx : down_idx;
  endfunction

  // Applies one accepted transaction to the shadow table and returns the
  // result the block must produce for it.
  function automatic nvbs_pkg::result_t apply_table_action(
      input logic [nvbs_pkg::ACT_W-1:0]  act,
      input logic [nvbs_pkg::DATA_W-1:0] key);
    nvbs_pkg::result_t r;
    int                hit;
    r = '{index: '0, value: '0, status: nvbs_pkg::ST_OK};
    case (act)
      nvbs_pkg::ACT_LOAD: begin
        if (entry_total < nvbs_pkg::TABLE_DEPTH) begin
          boundary_copy[entry_total] = key;
          entry_total++;
        end else begin
          r.status = nvbs_pkg::ST_FULL;
        end
      end
      nvbs_pkg::ACT_QUERY: begin
        if (entry_total == 0) begin
          r.status = nvbs_pkg::ST_EMPTY;
        end else begin
          hit = nearest_entry(key);
          r.index = hit[nvbs_pkg::IDX_OUT_W-1:0];
          r.value = boundary_copy[hit];
        end
      end
      nvbs_pkg::ACT_CLEAR: begin
        entry_total = 0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offers one transaction and holds it until the block takes it. The shadow
  // table is updated at acceptance; a typed expectation overrides the
  // predicted one for the directed rows.
  task automatic send_item(input logic [nvbs_pkg::ACT_W-1:0] act,
                           input logic [nvbs_pkg::DATA_W-1:0] key,
                           input bit typed = 1'b0,
                           input nvbs_pkg::result_t typed_res = '0);
    nvbs_pkg::result_t predicted;
    if (sender_gaps && !quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    predicted = apply_table_action(act, key);
    if (typed) predicted = typed_res;
    pending_results = {pending_results, predicted};
    items_sent++;
  endtask

  // Holds the sender back until every owed result has been delivered.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Picks a search key that lands on, between or around the loaded entries.
  function automatic logic [nvbs_pkg::DATA_W-1:0] pick_query_key();
    int           r;
    logic [32:0]  sum;
    if (entry_total == 0) return $urandom;
    r = $urandom_range(0, entry_total - 1);
    case ($urandom_range(0, 7))
      0: return boundary_copy[r];
      1: return boundary_copy[r] + $urandom_range(1, 3);
      2: return boundary_copy[r] - $urandom_range(1, 3);
      3, 4: begin
        // Halfway between neighbors, so ties and near-ties come up often.
        if (r + 1 >= entry_total) return boundary_copy[r];
        sum = {1'b0, boundary_copy[r]} + {1'b0, boundary_copy[r + 1]};
        return sum[32:1] + $urandom_range(0, 1);
      end
      5: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // One phase: clear, load a run of ascending boundaries with queries mixed in,
  // then a burst of queries with some noise. With scramble set, some loads
  // break the ascending order.
  task automatic run_phase(input int n_loads, input int n_queries, input bit scramble);
    logic [63:0]                 acc;
    logic [63:0]                 span;
    logic [nvbs_pkg::DATA_W-1:0] key;
    int                          k;
    send_item(nvbs_pkg::ACT_CLEAR, $urandom);
    span = 64'hFFFF_FFFF / n_loads;
    if ($urandom_range(0, 4) == 0) span = $urandom_range(0, 4);
    acc = $urandom_range(0, span[31:0]);
    for (k = 0; k < n_loads; k++) begin
      key = acc[31:0];
      if (scramble && $urandom_range(0, 9) == 0) key = $urandom;
      send_item(nvbs_pkg::ACT_LOAD, key);
      acc = acc + $urandom_range(0, span[31:0]);
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      if ($urandom_range(0, 5) == 0) send_item(nvbs_pkg::ACT_QUERY, pick_query_key());
    end
    for (k = 0; k < n_queries; k++) begin
      case ($urandom_range(0, 59))
        0, 1, 2: send_item(ACT_UNUSED, $urandom);
        3: send_item(nvbs_pkg::ACT_LOAD, $urandom);
        4: send_item(nvbs_pkg::ACT_CLEAR, $urandom);
        default: send_item(nvbs_pkg::ACT_QUERY, pick_query_key());
      endcase
    end
  endtask

  // Directed rows: edge cases whose answers are plain, plus a few left to the
  // predictor (unordered table contents).
  directed_row_t directed_rows [24] = '{
    '{nvbs_pkg::ACT_QUERY, 32'h1234_5678, 1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_EMPTY}},
    '{ACT_UNUSED,          32'hFFFF_FFFF, 1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_LOAD,  32'd10,        1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd0,         1'b1, '{10'd0, 32'd10, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b1, '{10'd0, 32'd10, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_LOAD,  32'd20,        1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_LOAD,  32'd30,        1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_LOAD,  32'hFFFF_FFF0, 1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b1, '{10'd3, 32'hFFFF_FFF0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd20,        1'b1, '{10'd1, 32'd20, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd25,        1'b1, '{10'd1, 32'd20, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd26,        1'b1, '{10'd2, 32'd30, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd24,        1'b1, '{10'd1, 32'd20, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'hFFFF_FFF0, 1'b1, '{10'd3, 32'hFFFF_FFF0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd10,        1'b1, '{10'd0, 32'd10, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_LOAD,  32'd5,         1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd6,         1'b0, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'h8000_0000, 1'b0, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{ACT_UNUSED,          32'd0,         1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_CLEAR, 32'd0,         1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'd7,         1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_EMPTY}},
    '{nvbs_pkg::ACT_LOAD,  32'd0,         1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}},
    '{nvbs_pkg::ACT_CLEAR, 32'hAAAA_AAAA, 1'b1, '{10'd0, 32'd0, nvbs_pkg::ST_OK}}
  };

  // Receiver: ready most of the time, with stall bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (receiver_gaps && !quiet && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker. Values read here are the ones present before this edge,
  // which are exactly the ones the handshake at this edge moves.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_tdata[9:0] !== oldest_result.index)
          report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                    out_tdata[9:0], oldest_result.index));
        if (out_tdata[41:10] !== oldest_result.value)
          report_mismatch($sformatf("nearest_value %h, expected %h",
                                    out_tdata[41:10], oldest_result.value));
        if (out_tuser !== oldest_result.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_tuser, oldest_result.status));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** nearest_value_binary_search: FAILED **");
      $finish;
    end
  end

  initial begin
    int row;
    int n_loads;
    int random_target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < $size(directed_rows); row++) begin
      send_item(directed_rows[row].act, directed_rows[row].data,
                directed_rows[row].typed, directed_rows[row].res);
    end
    // Let the block go fully idle once before random traffic starts.
    in_tvalid <= 1'b0;
    wait_drained();

    random_target = items_sent + RANDOM_ITEMS;
    while (items_sent < random_target) begin
      case ($urandom_range(0, 9))
        0: n_loads = $urandom_range(1, 3);
        1, 2: n_loads = $urandom_range(25, 120);
        default: n_loads = $urandom_range(4, 24);
      endcase
      sender_gaps = ($urandom_range(0, 3) != 0);
      receiver_gaps = ($urandom_range(0, 3) != 0);
      run_phase(n_loads, $urandom_range(4, 30), ($urandom_range(0, 4) == 0));
      if ($urandom_range(0, 2) == 0) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
    end

    // Fill the table completely; the last few loads must be refused as full,
    // and the queries then reach the top index.
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    run_phase(nvbs_pkg::TABLE_DEPTH + 3, 40, 1'b0);

    // Closing stretch at full rate on both sides.
    quiet = 1'b1;
    run_phase(16, 30, 1'b0);
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** nearest_value_binary_search: PASSED **");
    end else begin
      $display("** nearest_value_binary_search: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
src/nvbs_pkg.sv
src/nvbs_ram.sv
src/nvbs_ctrl.sv
src/nearest_value_binary_search.sv
tb/sv/nearest_value_binary_search_tb.sv
